>>> sv/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and codes for the length-prefixed packet splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

  localparam int LPS_PREFIX_BYTES = 4;
  localparam int LPS_LEN_W        = 32;
  localparam int LPS_LEN_BYTES    = LPS_LEN_W / 8;

  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_DROP   = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TRUNC   = 2'd1;
  localparam logic [1:0] ERR_OVERRUN = 2'd2;
  localparam logic [1:0] ERR_EMPTY   = 2'd3;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       byte_valid;
    logic       packet_start;
    logic       packet_end;
    logic       payload_done;
    logic [1:0] error_code;
  } lps_res_t;

endpackage

`default_nettype wire

>>> sv/lps_core.sv
// ----------------------------------------------------------------------------
// lps_core
// Prefix gathering, body counting and error detection, one request a cycle while step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_core
  import lps_pkg::*;
#(
  parameter int PREFIX_BYTES = LPS_PREFIX_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire logic       byte_present,
  input  wire logic       end_of_payload,
  output logic            res_vld,
  output lps_res_t        res
);

  localparam int CNT_W = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PREFIX_BYTES - 1);

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [LPS_LEN_W-1:0] length_r, length_nxt;
  logic [LPS_LEN_W-1:0] left_r, left_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic                 first_r, first_nxt;

  logic [LPS_LEN_W-1:0] lane;
  logic [LPS_LEN_W-1:0] gath;
  logic                 last_byte;
  logic                 clr;

  always_comb begin
    lane = '0;
    for (int k = 0; k < LPS_LEN_BYTES; k++) begin
      if ((k < PREFIX_BYTES) && (cnt_r == CNT_W'(k))) begin
        lane[8*k +: 8] = data_byte;
      end
    end
  end

  assign gath      = length_r | lane;
  assign last_byte = (left_r == LPS_LEN_W'(1));

  always_comb begin
    cnt_nxt    = cnt_r;
    length_nxt = length_r;
    left_nxt   = left_r;
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    res_vld    = 1'b0;
    res        = '0;
    clr        = 1'b0;
    if (step && (byte_present || end_of_payload)) begin
      case (phase_r)
        PH_PREFIX: begin
          if (!byte_present) begin
            res_vld          = 1'b1;
            res.payload_done = 1'b1;
            res.error_code   = (cnt_r != '0) ? ERR_TRUNC : ERR_NONE;
            clr              = 1'b1;
          end else if (cnt_r != CNT_LAST) begin
            cnt_nxt    = cnt_r + CNT_W'(1);
            length_nxt = gath;
            if (end_of_payload) begin
              res_vld          = 1'b1;
              res.payload_done = 1'b1;
              res.error_code   = ERR_TRUNC;
              clr              = 1'b1;
            end
          end else begin
            cnt_nxt = '0;
            if (gath == '0) begin
              res_vld          = 1'b1;
              res.payload_done = end_of_payload;
              res.error_code   = ERR_EMPTY;
              length_nxt       = '0;
              if (end_of_payload) begin
                clr = 1'b1;
              end else begin
                phase_nxt = PH_DROP;
              end
            end else if (end_of_payload) begin
              res_vld          = 1'b1;
              res.payload_done = 1'b1;
              res.error_code   = ERR_OVERRUN;
              clr              = 1'b1;
            end else begin
              left_nxt   = gath;
              length_nxt = '0;
              first_nxt  = 1'b1;
              phase_nxt  = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (!byte_present) begin
            res_vld          = 1'b1;
            res.payload_done = 1'b1;
            res.error_code   = ERR_OVERRUN;
            clr              = 1'b1;
          end else begin
            res_vld          = 1'b1;
            res.packet_byte  = data_byte;
            res.byte_valid   = 1'b1;
            res.packet_start = first_r;
            res.packet_end   = last_byte;
            first_nxt        = 1'b0;
            left_nxt         = left_r - LPS_LEN_W'(1);
            if (end_of_payload) begin
              res.payload_done = 1'b1;
              res.error_code   = last_byte ? ERR_NONE : ERR_OVERRUN;
              clr              = 1'b1;
            end else if (last_byte) begin
              phase_nxt = PH_PREFIX;
            end
          end
        end
        default: begin
          if (end_of_payload) begin
            res_vld          = 1'b1;
            res.payload_done = 1'b1;
            res.error_code   = ERR_NONE;
            clr              = 1'b1;
          end
        end
      endcase
    end
    if (clr) begin
      cnt_nxt    = '0;
      length_nxt = '0;
      left_nxt   = '0;
      phase_nxt  = PH_PREFIX;
      first_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      length_r <= '0;
      left_r   <= '0;
      phase_r  <= PH_PREFIX;
      first_r  <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      length_r <= length_nxt;
      left_r   <= left_nxt;
      phase_r  <= phase_nxt;
      first_r  <= first_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/lps_out_reg.sv
// ----------------------------------------------------------------------------
// lps_out_reg
// Result register with valid/ready handshake towards the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_out_reg
  import lps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step,
  input  wire logic     res_vld,
  input  wire lps_res_t res,
  input  wire logic     out_ready,
  output logic          in_ready,
  output logic          out_valid,
  output lps_res_t      out_res
);

  logic     vld_r, vld_nxt;
  lps_res_t res_r;
  logic     load;

  assign in_ready = !vld_r || out_ready;
  assign load     = step && res_vld;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

>>> sv/length_prefixed_packet_splitter_unit.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_splitter_unit
// Splits a byte stream into packets led by a little-endian length prefix.
//
//   channel  dir  handshake              payload
//   in_      in   in_valid / in_ready    data_byte, byte_present, end_of_payload
//   out_     out  out_valid / out_ready  packet_byte, flags, error_code
//
// One request per cycle while in_ready is high; each result is registered and appears in the cycle after its request.
// Throughput is bound by the single result register: a request is taken
// whenever that register is empty or being drained in the same cycle.
// A stalled result stalls the input only while out_ready is low.
// Synchronous active-low reset returns the splitter to prefix gathering.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_packet_splitter_unit
  import lps_pkg::*;
#(
  parameter int PREFIX_BYTES = LPS_PREFIX_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_byte_present,
  input  wire logic       in_end_of_payload,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_packet_byte,
  output logic            out_byte_valid,
  output logic            out_packet_start,
  output logic            out_packet_end,
  output logic            out_payload_done,
  output logic [1:0]      out_error_code
);

  logic     step;
  logic     res_vld;
  lps_res_t res;
  lps_res_t out_res;

  assign step = in_valid && in_ready;

  lps_core #(
    .PREFIX_BYTES (PREFIX_BYTES)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .data_byte      (in_data_byte),
    .byte_present   (in_byte_present),
    .end_of_payload (in_end_of_payload),
    .res_vld        (res_vld),
    .res            (res)
  );

  lps_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res_vld   (res_vld),
    .res       (res),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_packet_byte  = out_res.packet_byte;
  assign out_byte_valid   = out_res.byte_valid;
  assign out_packet_start = out_res.packet_start;
  assign out_packet_end   = out_res.packet_end;
  assign out_payload_done = out_res.payload_done;
  assign out_error_code   = out_res.error_code;

  a_start_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_start |-> out_byte_valid)
    else $error("packet start without body byte");

  a_err_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code != ERR_NONE) |-> !out_packet_end)
    else $error("error reported on a completed packet");

  a_trunc_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code == ERR_TRUNC) |-> out_payload_done && !out_byte_valid)
    else $error("truncated prefix not on payload end");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

endmodule

`default_nettype wire

>>> bench/lps_stream_checker.sv
// ----------------------------------------------------------------------------
// lps_stream_checker
// Watches both channels of the packet splitter. Every accepted request goes
// through a local model of the deframer, and every result it calls for is
// queued; each accepted result is matched against the oldest queued one.
// ----------------------------------------------------------------------------
module lps_stream_checker
  import lps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_present,
  input  logic       in_end_of_payload,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_packet_byte,
  input  logic       out_byte_valid,
  input  logic       out_packet_start,
  input  logic       out_packet_end,
  input  logic       out_payload_done,
  input  logic [1:0] out_error_code,
  output int         fail_count,
  output int         owed
);
  timeunit 1ns;
  timeprecision 1ps;

  int          prefix_count;
  logic [31:0] length_gather;
  logic [31:0] bytes_left;
  logic [1:0]  phase;
  logic        body_first;
  lps_res_t    owed_results[$];
  int          faults;

  initial begin
    faults = 0;
  end

  function automatic void clear_state();
    prefix_count  = 0;
    length_gather = '0;
    bytes_left    = '0;
    phase         = PH_PREFIX;
    body_first    = 1'b0;
  endfunction

  function automatic bit deframe_step(input logic [7:0] d, input logic present,
                                      input logic eop, output lps_res_t r);
    logic [63:0] widened;
    logic        start;
    logic        last;
    r = '0;
    if (!present && !eop) return 1'b0;
    case (phase)
      PH_PREFIX: begin
        if (!present) begin
          r.payload_done = 1'b1;
          r.error_code   = (prefix_count != 0) ? ERR_TRUNC : ERR_NONE;
          clear_state();
          return 1'b1;
        end
        widened = {32'd0, length_gather} | ({56'd0, d} << ((prefix_count % 8) * 8));
        length_gather = widened[31:0];
        prefix_count++;
        if (prefix_count < LPS_PREFIX_BYTES) begin
          if (eop) begin
            r.payload_done = 1'b1;
            r.error_code   = ERR_TRUNC;
            clear_state();
            return 1'b1;
          end
          return 1'b0;
        end
        prefix_count = 0;
        if (length_gather == '0) begin
          r.payload_done = eop;
          r.error_code   = ERR_EMPTY;
          if (eop) clear_state();
          else phase = PH_DROP;
          return 1'b1;
        end
        if (eop) begin
          r.payload_done = 1'b1;
          r.error_code   = ERR_OVERRUN;
          clear_state();
          return 1'b1;
        end
        bytes_left    = length_gather;
        length_gather = '0;
        body_first    = 1'b1;
        phase         = PH_BODY;
        return 1'b0;
      end
      PH_BODY: begin
        if (!present) begin
          r.payload_done = 1'b1;
          r.error_code   = ERR_OVERRUN;
          clear_state();
          return 1'b1;
        end
        start      = body_first;
        body_first = 1'b0;
        bytes_left = bytes_left - 1;
        last       = (bytes_left == '0);
        r.packet_byte  = d;
        r.byte_valid   = 1'b1;
        r.packet_start = start;
        r.packet_end   = last;
        if (eop) begin
          r.payload_done = 1'b1;
          r.error_code   = last ? ERR_NONE : ERR_OVERRUN;
          clear_state();
        end else if (last) begin
          phase = PH_PREFIX;
        end
        return 1'b1;
      end
      default: begin
        if (eop) begin
          r.payload_done = 1'b1;
          r.error_code   = ERR_NONE;
          clear_state();
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    lps_res_t fresh;
    lps_res_t seen;
    lps_res_t want;
    if (!rst_n) begin
      clear_state();
      owed_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (deframe_step(in_data_byte, in_byte_present, in_end_of_payload, fresh))
          owed_results.insert(owed_results.size(), fresh);
      end
      if (out_valid && out_ready) begin
        seen = {out_packet_byte, out_byte_valid, out_packet_start, out_packet_end,
                out_payload_done, out_error_code};
        if (owed_results.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected result byte=%02h v=%b s=%b e=%b done=%b err=%0d",
                     seen.packet_byte, seen.byte_valid, seen.packet_start,
                     seen.packet_end, seen.payload_done, seen.error_code);
        end else begin
          want = owed_results.pop_front();
          if (seen.packet_byte !== want.packet_byte || seen.byte_valid !== want.byte_valid ||
              seen.packet_start !== want.packet_start ||
              seen.packet_end !== want.packet_end ||
              seen.payload_done !== want.payload_done ||
              seen.error_code !== want.error_code) begin
            faults++;
            if (faults <= 10)
              $display("mismatch want byte=%02h v=%b s=%b e=%b done=%b err=%0d",
                       want.packet_byte, want.byte_valid, want.packet_start,
                       want.packet_end, want.payload_done, want.error_code,
                       " / got byte=%02h v=%b s=%b e=%b done=%b err=%0d",
                       seen.packet_byte, seen.byte_valid, seen.packet_start,
                       seen.packet_end, seen.payload_done, seen.error_code);
          end
        end
      end
    end
    fail_count <= faults;
    owed <= owed_results.size();
  end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives length-prefixed payloads into the packet splitter: a directed run
// over prefix errors, empty packets and overruns, then random payloads, mostly
// well formed, with random gaps on both channels. The checker does the rest.
// ----------------------------------------------------------------------------
module testbench
  import lps_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_byte_present;
  logic       in_end_of_payload;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_packet_byte;
  logic       out_byte_valid;
  logic       out_packet_start;
  logic       out_packet_end;
  logic       out_payload_done;
  logic [1:0] out_error_code;
  int         fail_count;
  int         owed;
  int         cycles;
  int         requests_sent;
  bit         steady;
  bit         drained_once;

  length_prefixed_packet_splitter_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_payload (in_end_of_payload),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_packet_byte   (out_packet_byte),
    .out_byte_valid    (out_byte_valid),
    .out_packet_start  (out_packet_start),
    .out_packet_end    (out_packet_end),
    .out_payload_done  (out_payload_done),
    .out_error_code    (out_error_code)
  );

  lps_stream_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_payload (in_end_of_payload),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_packet_byte   (out_packet_byte),
    .out_byte_valid    (out_byte_valid),
    .out_packet_start  (out_packet_start),
    .out_packet_end    (out_packet_end),
    .out_payload_done  (out_payload_done),
    .out_error_code    (out_error_code),
    .fail_count        (fail_count),
    .owed              (owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 35);
  end

  // one request; starts and ends on a falling edge
  task automatic offer(input logic [7:0] d, input logic present, input logic eop);
    while (!steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= d;
    in_byte_present   <= present;
    in_end_of_payload <= eop;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (present || eop) requests_sent++;
  endtask

  task automatic offer_length(input logic [31:0] len, input logic eop_on_last);
    for (int n = 0; n < LPS_PREFIX_BYTES; n++)
      offer(8'(len >> (8 * n)), 1'b1, eop_on_last && n == LPS_PREFIX_BYTES - 1);
  endtask

  task automatic send_payload();
    logic [7:0]  stream[$];
    logic [31:0] len;
    int          mode;
    int          npk;
    int          zero_at;
    int          cut;
    bit          bare_end;
    mode    = $urandom_range(99);
    npk     = $urandom_range(1, 4);
    zero_at = (mode >= 70 && mode < 80) ? $urandom_range(npk - 1) : -1;
    for (int k = 0; k < npk; k++) begin
      if (k == zero_at) len = '0;
      else if (mode >= 90 && mode < 95 && k == 0) len = $urandom();
      else if ($urandom_range(9) == 0) len = $urandom_range(9, 40);
      else len = $urandom_range(1, 8);
      for (int n = 0; n < LPS_PREFIX_BYTES; n++)
        stream.insert(stream.size(), 8'(len >> (8 * n)));
      if (len <= 64) begin
        for (int n = 0; n < len; n++) stream.insert(stream.size(), 8'($urandom()));
      end else begin
        repeat ($urandom_range(0, 6)) stream.insert(stream.size(), 8'($urandom()));
      end
    end
    if (mode >= 80 && mode < 90) begin
      cut = $urandom_range(1, stream.size() - 1);
      while (stream.size() > cut) void'(stream.pop_back());
    end
    if (mode >= 95) stream.delete();
    bare_end = (stream.size() == 0) || ($urandom_range(3) == 0);
    foreach (stream[i]) begin
      if ($urandom_range(19) == 0) offer(8'($urandom()), 1'b0, 1'b0);
      offer(stream[i], 1'b1, !bare_end && i == stream.size() - 1);
    end
    if (bare_end) offer(8'($urandom()), 1'b0, 1'b1);
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_data_byte      = '0;
    in_byte_present   = 1'b0;
    in_end_of_payload = 1'b0;
    requests_sent     = 0;
    steady            = 1'b0;
    drained_once      = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed
    offer(8'h00, 1'b0, 1'b0);              // idle request
    offer(8'h00, 1'b0, 1'b1);              // empty payload
    offer(8'hFF, 1'b1, 1'b0);              // truncated prefix, bare end
    offer(8'h00, 1'b0, 1'b1);
    offer_length(32'd1, 1'b0);             // one-byte packet ending the payload
    offer(8'hFF, 1'b1, 1'b1);
    offer_length(32'd0, 1'b0);             // empty packet, then dropped bytes
    offer(8'hAA, 1'b1, 1'b0);
    offer(8'h55, 1'b0, 1'b1);
    offer_length(32'hFFFF_FFFF, 1'b0);     // huge length, payload ends in body
    offer(8'h00, 1'b0, 1'b1);
    offer_length(32'd2, 1'b1);             // payload ends on last prefix byte

    // random payloads
    while (requests_sent < 620) begin
      steady = (requests_sent >= 260 && requests_sent < 420);
      send_payload();
      if (!drained_once && requests_sent >= 150) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (owed != 0) @(negedge clk);
        drained_once = 1'b1;
      end
    end

    in_valid <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
